[src/ltbp_pkg.sv]
// ltbp_pkg: shared types and constants for the link token bucket policer
// no dependencies; imported by link_token_bucket_policer
package ltbp_pkg;

    // default number of nodes
    localparam int MAX_NODES_DEF = 8;

    // field and state widths
    localparam int OP_W      = 1;
    localparam int NODE_W    = 3;
    localparam int RATE_W    = 20;
    localparam int BYTES_W   = 24;
    localparam int STAMP_W   = 48;
    localparam int FILL_W    = 47;
    localparam int COUNT_W   = 4;
    localparam int BUCKET_W  = FILL_W + STAMP_W;

    // shared multiplier operand widths
    localparam int MUL_A_W   = 27;
    localparam int MUL_B_W   = 20;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;

    // arithmetic constants
    localparam logic [MUL_B_W-1:0] US_PER_S       = 20'd1000000;
    localparam logic [MUL_B_W-1:0] UB_PER_KBPS_US = 20'd125;
    localparam logic [RATE_W-1:0]  RESET_RATE     = 20'd72000;
    localparam logic [COUNT_W-1:0] RESET_NODES    = 4'd8;

    // operation codes
    localparam logic [OP_W-1:0] OP_RATE = 1'b0;
    localparam logic [OP_W-1:0] OP_MSG  = 1'b1;

    // register map (word index)
    localparam int          CFG_ADDR_W     = 3;
    localparam int          CFG_DATA_W     = 32;
    localparam logic        REG_NODE_COUNT = 1'b0;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_NEED,
        S_SCAN,
        S_READ,
        S_CAP,
        S_REFILL,
        S_APPLY,
        S_EMIT
    } ltbp_state_t;

endpackage

[src/link_token_bucket_policer.sv]
// channel  | handshake               | payload
// in       | in_valid / in_stall     | operation, sender, receiver, rate_kbps, size_bytes, now_us
// out      | out_valid / out_stall   | dest, relayed, last
// cfg      | psel, penable, pwrite   | paddr, pwdata, prdata, pready (node_count at 0)
//
// a rate update is written from idle; a message runs a need step, then scan, read, cap,
// refill, apply and emit per visited receiver, a scan per skipped index and a final scan
// per-receiver cost is set by the shared 27x20 multiplier, used three times per link
// reset clears valid bits for link rates and bucket use at once; no clearing pass
// in_stall stays high while a message is at work; a stalled verdict holds the sequencer
// depends on ltbp_pkg and ltbp_ram
module link_token_bucket_policer
    import ltbp_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // input transactions
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [OP_W-1:0]       operation,
    input  logic [NODE_W-1:0]     sender,
    input  logic [NODE_W-1:0]     receiver,
    input  logic [RATE_W-1:0]     rate_kbps,
    input  logic [BYTES_W-1:0]    size_bytes,
    input  logic [STAMP_W-1:0]    now_us,
    // output transactions
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [NODE_W-1:0]     dest,
    output logic                  relayed,
    output logic                  last,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int LINKS  = MAX_NODES * MAX_NODES;
    localparam int LINK_W = $clog2(LINKS);
    localparam int IDX_W  = $clog2(MAX_NODES + 1);

    // control registers
    ltbp_state_t          state_reg, state_next;
    logic [COUNT_W-1:0]   node_count_reg, node_count_next;
    logic [LINKS-1:0]     rate_valid_reg, rate_valid_next;
    logic [LINKS-1:0]     started_reg, started_next;
    logic                 out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]     r_reg, r_next;

    // payload registers
    logic [NODE_W-1:0]    snd_reg, snd_next;
    logic [BYTES_W-1:0]   bytes_reg, bytes_next;
    logic [STAMP_W-1:0]   now_reg, now_next;
    logic [LINK_W-1:0]    link_reg, link_next;
    logic [FILL_W-1:0]    need_reg, need_next;
    logic [MUL_A_W-1:0]   rate125_reg, rate125_next;
    logic [FILL_W-1:0]    cap_reg, cap_next;
    logic [FILL_W-1:0]    refill_reg, refill_next;
    logic [FILL_W-1:0]    fill_reg, fill_next;
    logic [STAMP_W-1:0]   stamp_reg, stamp_next;
    logic [MUL_B_W-1:0]   elapsed_reg, elapsed_next;
    logic                 later_reg, later_next;
    logic [NODE_W-1:0]    dest_reg, dest_next;
    logic                 relayed_reg, relayed_next;
    logic                 last_reg, last_next;

    // memory ports
    logic                 rate_wr_en;
    logic [LINK_W-1:0]    rate_wr_addr;
    logic [RATE_W-1:0]    rate_rd;
    logic                 rd_en;
    logic [LINK_W-1:0]    link_calc;
    logic                 bucket_wr_en;
    logic [BUCKET_W-1:0]  bucket_wr_data;
    logic [BUCKET_W-1:0]  bucket_rd;

    // shared multiplier
    logic [MUL_A_W-1:0]   mul_a;
    logic [MUL_B_W-1:0]   mul_b;
    logic [MUL_P_W-1:0]   mul_p;

    // misc combinational values
    logic [IDX_W-1:0]     count_eff;
    logic                 cfg_idx;
    logic                 cfg_wr;
    logic                 rate_ok;
    logic                 out_free;
    logic [RATE_W-1:0]    rate_eff;
    logic [STAMP_W:0]     diff;
    logic [FILL_W:0]      sum;
    logic                 pass;
    logic                 last_calc;

    // effective node count
    assign count_eff = (32'(node_count_reg) > MAX_NODES) ? IDX_W'(MAX_NODES)
                                                         : IDX_W'(node_count_reg);

    // configuration decode
    assign cfg_idx = paddr[2];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_comb
    begin
        unique case (cfg_idx)
            REG_NODE_COUNT: prdata = CFG_DATA_W'(node_count_reg);
            default:        prdata = '0;
        endcase
    end

    // rate update address and validity
    assign rate_ok      = (sender != receiver) && (32'(sender) < MAX_NODES)
                          && (32'(receiver) < MAX_NODES);
    assign rate_wr_addr = LINK_W'(32'(sender) * MAX_NODES + 32'(receiver));
    assign link_calc    = LINK_W'(32'(snd_reg) * MAX_NODES + 32'(r_reg));

    // link rate and bucket memories
    ltbp_ram #(
        .WIDTH (RATE_W),
        .DEPTH (LINKS)
    ) u_rate_ram (
        .clk     (clk),
        .wr_en   (rate_wr_en),
        .wr_addr (rate_wr_addr),
        .wr_data (rate_kbps),
        .rd_en   (rd_en),
        .rd_addr (link_calc),
        .rd_data (rate_rd)
    );

    ltbp_ram #(
        .WIDTH (BUCKET_W),
        .DEPTH (LINKS)
    ) u_bucket_ram (
        .clk     (clk),
        .wr_en   (bucket_wr_en),
        .wr_addr (link_reg),
        .wr_data (bucket_wr_data),
        .rd_en   (rd_en),
        .rd_addr (link_calc),
        .rd_data (bucket_rd)
    );

    // values used inside the sequencer
    assign rate_eff  = rate_valid_reg[link_reg] ? rate_rd : RESET_RATE;
    assign diff      = {1'b0, now_reg} - {1'b0, stamp_reg};
    assign sum       = {1'b0, fill_reg} + {1'b0, refill_reg};
    assign pass      = (fill_reg >= need_reg);
    assign out_free  = !out_valid_reg || !out_stall;
    assign last_calc = (32'(r_reg) + 1 >= 32'(count_eff))
                       || ((32'(r_reg) + 1 == 32'(snd_reg)) && (32'(r_reg) + 2 >= 32'(count_eff)));

    // shared multiplier operand select
    always_comb
    begin
        unique case (state_reg)
            S_NEED:
            begin
                mul_a = MUL_A_W'(bytes_reg);
                mul_b = US_PER_S;
            end
            S_READ:
            begin
                mul_a = MUL_A_W'(rate_eff);
                mul_b = UB_PER_KBPS_US;
            end
            S_CAP:
            begin
                mul_a = rate125_reg;
                mul_b = US_PER_S;
            end
            S_REFILL:
            begin
                mul_a = rate125_reg;
                mul_b = elapsed_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = MUL_P_W'(MUL_P_W'(mul_a) * MUL_P_W'(mul_b));

    // sequencer next state and datapath
    always_comb
    begin
        state_next      = state_reg;
        node_count_next = node_count_reg;
        rate_valid_next = rate_valid_reg;
        started_next    = started_reg;
        out_valid_next  = out_valid_reg && out_stall;
        r_next          = r_reg;
        snd_next        = snd_reg;
        bytes_next      = bytes_reg;
        now_next        = now_reg;
        link_next       = link_reg;
        need_next       = need_reg;
        rate125_next    = rate125_reg;
        cap_next        = cap_reg;
        refill_next     = refill_reg;
        fill_next       = fill_reg;
        stamp_next      = stamp_reg;
        elapsed_next    = elapsed_reg;
        later_next      = later_reg;
        dest_next       = dest_reg;
        relayed_next    = relayed_reg;
        last_next       = last_reg;
        rate_wr_en      = 1'b0;
        rd_en           = 1'b0;
        bucket_wr_en    = 1'b0;
        bucket_wr_data  = {stamp_reg, fill_reg};

        // register write
        if (cfg_wr && (cfg_idx == REG_NODE_COUNT))
        begin
            node_count_next = pwdata[COUNT_W-1:0];
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (operation == OP_RATE)
                    begin
                        if (rate_ok)
                        begin
                            rate_wr_en                    = 1'b1;
                            rate_valid_next[rate_wr_addr] = 1'b1;
                        end
                    end
                    else
                    begin
                        snd_next   = sender;
                        bytes_next = size_bytes;
                        now_next   = now_us;
                        r_next     = '0;
                        if (32'(sender) < 32'(count_eff))
                        begin
                            state_next = S_NEED;
                        end
                    end
                end
            end
            // size in microbytes
            S_NEED:
            begin
                need_next  = FILL_W'(mul_p);
                state_next = S_SCAN;
            end
            // pick next receiver, skipping the sender
            S_SCAN:
            begin
                if (32'(r_reg) >= 32'(count_eff))
                begin
                    state_next = S_IDLE;
                end
                else if (32'(r_reg) == 32'(snd_reg))
                begin
                    r_next = IDX_W'(r_reg + 1'b1);
                end
                else
                begin
                    rd_en      = 1'b1;
                    link_next  = link_calc;
                    state_next = S_READ;
                end
            end
            // load bucket; first use starts empty at the current time
            S_READ:
            begin
                rate125_next = MUL_A_W'(mul_p);
                if (started_reg[link_reg])
                begin
                    fill_next  = bucket_rd[FILL_W-1:0];
                    stamp_next = bucket_rd[BUCKET_W-1:FILL_W];
                end
                else
                begin
                    fill_next  = '0;
                    stamp_next = now_reg;
                end
                state_next = S_CAP;
            end
            // bucket cap and clamped elapsed time
            S_CAP:
            begin
                cap_next     = FILL_W'(mul_p);
                later_next   = !diff[STAMP_W] && (diff[STAMP_W-1:0] != '0);
                elapsed_next = (diff[STAMP_W-1:0] > STAMP_W'(US_PER_S))
                               ? US_PER_S : diff[MUL_B_W-1:0];
                state_next   = S_REFILL;
            end
            S_REFILL:
            begin
                refill_next = FILL_W'(mul_p);
                state_next  = S_APPLY;
            end
            // refill capped at one second of rate
            S_APPLY:
            begin
                if (later_reg)
                begin
                    fill_next  = (sum > {1'b0, cap_reg}) ? cap_reg : sum[FILL_W-1:0];
                    stamp_next = now_reg;
                end
                state_next = S_EMIT;
            end
            // pass test, write back, verdict
            S_EMIT:
            begin
                if (out_free)
                begin
                    bucket_wr_en           = 1'b1;
                    bucket_wr_data         = {stamp_reg, pass ? (fill_reg - need_reg) : fill_reg};
                    started_next[link_reg] = 1'b1;
                    out_valid_next         = 1'b1;
                    dest_next              = NODE_W'(r_reg);
                    relayed_next           = pass;
                    last_next              = last_calc;
                    r_next                 = IDX_W'(r_reg + 1'b1);
                    state_next             = S_SCAN;
                end
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= RESET_NODES;
            rate_valid_reg <= '0;
            started_reg    <= '0;
            out_valid_reg  <= 1'b0;
            r_reg          <= '0;
        end
        else
        begin
            node_count_reg <= node_count_next;
            rate_valid_reg <= rate_valid_next;
            started_reg    <= started_next;
            out_valid_reg  <= out_valid_next;
            r_reg          <= r_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        snd_reg     <= snd_next;
        bytes_reg   <= bytes_next;
        now_reg     <= now_next;
        link_reg    <= link_next;
        need_reg    <= need_next;
        rate125_reg <= rate125_next;
        cap_reg     <= cap_next;
        refill_reg  <= refill_next;
        fill_reg    <= fill_next;
        stamp_reg   <= stamp_next;
        elapsed_reg <= elapsed_next;
        later_reg   <= later_next;
        dest_reg    <= dest_next;
        relayed_reg <= relayed_next;
        last_reg    <= last_next;
    end

    // outputs
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign dest      = dest_reg;
    assign relayed   = relayed_reg;
    assign last      = last_reg;

    // a new verdict only comes from the emit step
    a_verdict_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_EMIT))
        else $error("verdict appeared outside emit step");

    // the sender's own link is never visited
    a_no_self_visit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (32'(r_reg) != 32'(snd_reg)))
        else $error("sender link visited");

    // while a verdict that is not the final one waits, the message is still at work
    a_busy_until_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last) |-> in_stall)
        else $error("block idle before final verdict");

endmodule

[src/ltbp_ram.sv]
// ltbp_ram: generic single write port, single read port ram
// registered read data; no dependencies
module ltbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
